/* rtl/assert_macros.svh */
// Assertion helpers for the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KST_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kst assertion failed");

// Next-cycle implication, disabled during reset.
`define KST_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kst assertion failed");

`endif

/* rtl/kst_pkg.sv */
`default_nettype none
package kst_pkg;

   // Field widths of the stream payload
   localparam int IN_DIM_W    = 13;
   localparam int RANK_W      = 25;
   localparam int VALUE_W     = 25;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 32;

   // Default size bound
   localparam int MAX_DIM_DEF = 4096;

   // Microprogram geometry
   localparam int STEP_W = 3;

   // Step addresses
   localparam logic [STEP_W-1:0] ST_WAIT   = 3'd0;
   localparam logic [STEP_W-1:0] ST_INIT   = 3'd1;
   localparam logic [STEP_W-1:0] ST_TEST   = 3'd2;
   localparam logic [STEP_W-1:0] ST_PROBE  = 3'd3;
   localparam logic [STEP_W-1:0] ST_WALK   = 3'd4;
   localparam logic [STEP_W-1:0] ST_DECIDE = 3'd5;
   localparam logic [STEP_W-1:0] ST_OUT    = 3'd6;
   localparam logic [STEP_W-1:0] ST_RET    = 3'd7;

   // Datapath operations
   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_INIT,
      OP_PROBE,
      OP_WALK,
      OP_DECIDE,
      OP_OUT
   } op_type;

   // Jump conditions
   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_SEARCH_DONE,
      C_WALK_MORE,
      C_RSP_BUSY
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } ctrl_word_type;

   typedef struct packed {
      logic req_valid;
      logic search_done;
      logic walk_more;
      logic rsp_busy;
   } status_type;

   // Microprogram: jump to target when the condition holds, else step on
   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      case (step)
         ST_WAIT:   w = '{op: OP_LOAD,   cond: C_NO_REQ,      target: ST_WAIT};
         ST_INIT:   w = '{op: OP_INIT,   cond: C_NEVER,       target: ST_WAIT};
         ST_TEST:   w = '{op: OP_NOP,    cond: C_SEARCH_DONE, target: ST_OUT};
         ST_PROBE:  w = '{op: OP_PROBE,  cond: C_NEVER,       target: ST_WAIT};
         ST_WALK:   w = '{op: OP_WALK,   cond: C_WALK_MORE,   target: ST_WALK};
         ST_DECIDE: w = '{op: OP_DECIDE, cond: C_ALWAYS,      target: ST_TEST};
         ST_OUT:    w = '{op: OP_OUT,    cond: C_RSP_BUSY,    target: ST_OUT};
         ST_RET:    w = '{op: OP_NOP,    cond: C_ALWAYS,      target: ST_WAIT};
         default:   w = '{op: OP_NOP,    cond: C_ALWAYS,      target: ST_WAIT};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

/* rtl/kst_sequencer.sv */
`default_nettype none
module kst_sequencer (
   input  wire                    clock,
   input  wire                    reset,
   input  kst_pkg::status_type    status,
   output kst_pkg::ctrl_word_type ctrl
);
   import kst_pkg::*;

   logic [STEP_W-1:0] upc_ff;
   logic [STEP_W-1:0] upc_in;
   logic              take;

   // Fetch the control word of the current step
   assign ctrl = ucode(upc_ff);

   // Evaluate the jump condition
   always_comb begin
      case (ctrl.cond)
         C_NEVER:       take = 1'b0;
         C_ALWAYS:      take = 1'b1;
         C_NO_REQ:      take = !status.req_valid;
         C_SEARCH_DONE: take = status.search_done;
         C_WALK_MORE:   take = status.walk_more;
         C_RSP_BUSY:    take = status.rsp_busy;
         default:       take = 1'b0;
      endcase
   end

   // Jump or advance
   always_comb begin
      if (take) begin
         upc_in = ctrl.target;
      end else begin
         upc_in = upc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ST_WAIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/kst_datapath.sv */
`default_nettype none
module kst_datapath #(
   parameter int MAX_DIM = kst_pkg::MAX_DIM_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  kst_pkg::ctrl_word_type               ctrl,
   output kst_pkg::status_type                  status,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [kst_pkg::REQ_TDATA_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [kst_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);
   import kst_pkg::*;

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int PROD_W = 2 * DIM_W;
   localparam int CMP_W  = (PROD_W > RANK_W) ? PROD_W : RANK_W;

   // Unpacked request fields
   logic [IN_DIM_W-1:0] req_rows;
   logic [IN_DIM_W-1:0] req_cols;
   logic [RANK_W-1:0]   req_rank;
   logic [DIM_W-1:0]    rows_sat;
   logic [DIM_W-1:0]    cols_sat;

   logic [DIM_W-1:0]    rows_ff, rows_in;
   logic [DIM_W-1:0]    cols_ff, cols_in;
   logic [RANK_W-1:0]   rank_ff, rank_in;
   logic [PROD_W-1:0]   lo_ff, lo_in;
   logic [PROD_W-1:0]   hi_ff, hi_in;
   logic [PROD_W-1:0]   mid_ff, mid_in;
   logic [DIM_W-1:0]    i_ff, i_in;
   logic [DIM_W:0]      j_ff, j_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [PROD_W-1:0]   count_ff, count_in;
   logic [VALUE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [PROD_W-1:0]   dim_prod;
   logic                dim_zero;
   logic                walk_more;
   logic                rsp_busy;
   logic                req_beat;
   logic                count_low;

   assign req_rows = req_tdata[IN_DIM_W-1:0];
   assign req_cols = req_tdata[2*IN_DIM_W-1:IN_DIM_W];
   assign req_rank = req_tdata[2*IN_DIM_W+RANK_W-1:2*IN_DIM_W];

   // Saturate dimensions to the size bound
   assign rows_sat = (32'(req_rows) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(req_rows);
   assign cols_sat = (32'(req_cols) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(req_cols);

   // Handshakes
   assign req_tready = (ctrl.op == OP_LOAD);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_busy   = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

   // Search and staircase flags
   assign dim_prod  = rows_ff * cols_ff;
   assign dim_zero  = (rows_ff == '0) || (cols_ff == '0);
   assign walk_more = (i_ff != '0) && (j_ff <= {1'b0, cols_ff});
   assign count_low = CMP_W'(count_ff) < CMP_W'(rank_ff);

   assign status.req_valid   = req_tvalid;
   assign status.search_done = !(lo_ff < hi_ff);
   assign status.walk_more   = walk_more;
   assign status.rsp_busy    = rsp_busy;

   // Execute the current control word
   always_comb begin
      rows_in     = rows_ff;
      cols_in     = cols_ff;
      rank_in     = rank_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      prod_in     = prod_ff;
      count_in    = count_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = (rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff;
      case (ctrl.op)
         OP_LOAD: begin
            if (req_beat) begin
               rows_in = rows_sat;
               cols_in = cols_sat;
               rank_in = req_rank;
            end
         end
         OP_INIT: begin
            // an empty table answers zero: lo == hi == 0 ends the search
            lo_in = dim_zero ? '0 : PROD_W'(1);
            hi_in = dim_prod;
         end
         OP_PROBE: begin
            mid_in   = lo_ff + ((hi_ff - lo_ff) >> 1);
            i_in     = rows_ff;
            j_in     = (DIM_W+1)'(1);
            prod_in  = PROD_W'(rows_ff);
            count_in = '0;
         end
         OP_WALK: begin
            // walk the staircase: one column or one row per beat of work
            if (walk_more) begin
               if (prod_ff <= mid_ff) begin
                  count_in = count_ff + PROD_W'(i_ff);
                  j_in     = j_ff + 1'b1;
                  prod_in  = prod_ff + PROD_W'(i_ff);
               end else begin
                  i_in    = i_ff - 1'b1;
                  prod_in = prod_ff - PROD_W'(j_ff);
               end
            end
         end
         OP_DECIDE: begin
            if (count_low) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
         end
         OP_OUT: begin
            if (!rsp_busy) begin
               rsp_data_in  = VALUE_W'(lo_ff);
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rows_ff     <= rows_in;
      cols_ff     <= cols_in;
      rank_ff     <= rank_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      prod_ff     <= prod_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/kth_smallest_product_table.sv */
// A request beat loads rows, cols and rank; a binary search of P = ceil(log2(rows*cols))
// probes follows, each a probe, a staircase walk of W <= rows + cols steps (one per cycle) and a
// decide step; the output step then offers the result. Throughput: one query at a time; the
// staircase walk in the datapath bounds it. A new request is taken while a response waits.
// Reset: synchronous, active high; clears the step counter and the response valid only.
`default_nettype none
module kth_smallest_product_table #(
   parameter int MAX_DIM = kst_pkg::MAX_DIM_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // fields from bit 0: rows[12:0], cols[25:13], rank[50:26], zero pad
   input  wire  [kst_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // fields from bit 0: value[24:0], zero pad
   output logic [kst_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import kst_pkg::*;
   `include "assert_macros.svh"

   ctrl_word_type ctrl;
   status_type    status;

   kst_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   kst_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A request beat starts a query: the sequencer leaves the wait step
   `KST_ASSERT_NXT(a_req_starts, clock, reset, req_tvalid && req_tready, !req_tready)
   // A finished walk hands over to the decide step
   `KST_ASSERT_NXT(a_walk_ends, clock, reset, (ctrl.op == OP_WALK) && !status.walk_more, ctrl.op == OP_DECIDE)
   // A response appears only from the output step
   `KST_ASSERT_IMP(a_rsp_source, clock, reset, $rose(rsp_tvalid), $past(ctrl.op == OP_OUT))

endmodule
`default_nettype wire
